FILE: hw/rtl/ldq_pkg.sv
`timescale 1ns / 1ps

package ldq_pkg;

  localparam int LANES_DEF     = 16;
  localparam int ACT_WIDTH_DEF = 16;

  localparam int WBITS_W      = 64;
  localparam int ACT_SEG_W    = 64;
  localparam int ACT_BUS_W    = 4 * ACT_SEG_W;
  localparam int COUNT_W      = 5;
  localparam int FMT_W        = 2;
  localparam int SCALE_W      = 16;
  localparam int GSUM_W       = 32;
  localparam int SPROD_W      = GSUM_W + SCALE_W;
  localparam int TOTAL_W      = 64;

  localparam int NIB_W        = 4;
  localparam int CRUMB_W      = 2;
  localparam int CODE_W       = 5;
  localparam int INT4_BIAS    = 8;
  localparam int INT2_BIAS    = 2;
  localparam int INT3_BIAS    = 4;
  localparam int INT3_HI_BASE = 32;
  localparam int PART_LANES   = 4;

  typedef enum logic [FMT_W-1:0] {
    FMT_INT4 = 2'd0,
    FMT_INT2 = 2'd1,
    FMT_INT3 = 2'd2
  } fmt_t;

  typedef struct packed {
    logic                      valid;
    logic                      glast;
    logic                      vlast;
    logic signed [SCALE_W-1:0] scale;
  } stage_t;

endpackage

FILE: hw/rtl/ldq_if.sv
`timescale 1ns / 1ps

interface ldq_in_if import ldq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [WBITS_W-1:0]        weight_bits;
  logic [ACT_SEG_W-1:0]      acts_lanes_0_3;
  logic [ACT_SEG_W-1:0]      acts_lanes_4_7;
  logic [ACT_SEG_W-1:0]      acts_lanes_8_11;
  logic [ACT_SEG_W-1:0]      acts_lanes_12_15;
  logic [COUNT_W-1:0]        valid_count;
  logic signed [SCALE_W-1:0] group_scale;
  logic                      group_last;
  logic                      vector_last;

  modport source (
    output valid, weight_bits, acts_lanes_0_3, acts_lanes_4_7, acts_lanes_8_11,
           acts_lanes_12_15, valid_count, group_scale, group_last, vector_last,
    input  ready
  );
  modport sink (
    input  valid, weight_bits, acts_lanes_0_3, acts_lanes_4_7, acts_lanes_8_11,
           acts_lanes_12_15, valid_count, group_scale, group_last, vector_last,
    output ready
  );
endinterface

interface ldq_out_if import ldq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [TOTAL_W-1:0] dot_value;

  modport source (output valid, dot_value, input ready);
  modport sink (input valid, dot_value, output ready);
endinterface

interface ldq_cfg_if import ldq_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [FMT_W-1:0] weight_format;

  modport source (output valid, weight_format, input ready);
  modport sink (input valid, weight_format, output ready);
endinterface

FILE: hw/rtl/ldq_lane.sv
`timescale 1ns / 1ps

module ldq_lane import ldq_pkg::*; #(
  parameter int ACT_WIDTH = ACT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic [FMT_W-1:0]                     fmt,
  input  logic                                 lane_on,
  input  logic [NIB_W-1:0]                     nib,
  input  logic [CRUMB_W-1:0]                   crumb,
  input  logic                                 hib,
  input  logic signed [ACT_WIDTH-1:0]          act,
  output logic signed [ACT_WIDTH+CODE_W-1:0]   prod
);

  localparam int PW = ACT_WIDTH + CODE_W;

  logic signed [CODE_W-1:0] code;
  logic signed [PW-1:0]     mul;
  logic signed [PW-1:0]     prod_r;

  always_comb begin
    case (fmt)
      FMT_INT2: begin
        code = {{(CODE_W-CRUMB_W){1'b0}}, crumb} - CODE_W'(INT2_BIAS);
      end
      FMT_INT3: begin
        code = {{(CODE_W-CRUMB_W-1){1'b0}}, hib, crumb} - CODE_W'(INT3_BIAS);
      end
      default: begin
        code = {{(CODE_W-NIB_W){1'b0}}, nib} - CODE_W'(INT4_BIAS);
      end
    endcase
    mul = code * act;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= lane_on ? mul : '0;
    end
  end

  assign prod = prod_r;

endmodule

FILE: hw/rtl/ldq_merge.sv
`timescale 1ns / 1ps

module ldq_merge import ldq_pkg::*; #(
  parameter int LANES     = LANES_DEF,
  parameter int ACT_WIDTH = ACT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  stage_t                             in_ctl,
  input  logic signed [ACT_WIDTH+CODE_W-1:0] prods [LANES],
  output stage_t                             out_ctl,
  output logic signed [GSUM_W-1:0]           gsum_out
);

  localparam int PW    = ACT_WIDTH + CODE_W;
  localparam int NPART = (LANES + PART_LANES - 1) / PART_LANES;
  localparam int PSW   = PW + 2;

  logic signed [PW-1:0]     pad      [NPART*PART_LANES];
  logic signed [PSW-1:0]    part_nxt [NPART];
  logic signed [PSW-1:0]    part_r   [NPART];
  stage_t                   ctl2_r;
  stage_t                   ctl3_r;
  logic signed [GSUM_W-1:0] chunk;
  logic signed [GSUM_W-1:0] gsum_r;
  logic signed [GSUM_W-1:0] gsum_nxt;
  logic signed [GSUM_W-1:0] gs_r;
  logic                     grp_end;

  always_comb begin
    for (int i = 0; i < NPART * PART_LANES; i++) begin
      pad[i] = '0;
    end
    for (int i = 0; i < LANES; i++) begin
      pad[i] = prods[i];
    end
    for (int p = 0; p < NPART; p++) begin
      part_nxt[p] = '0;
      for (int k = 0; k < PART_LANES; k++) begin
        part_nxt[p] = part_nxt[p] + PSW'(pad[p*PART_LANES+k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      part_r <= part_nxt;
    end
  end

  always_comb begin
    chunk = '0;
    for (int p = 0; p < NPART; p++) begin
      chunk = chunk + GSUM_W'(part_r[p]);
    end
    gsum_nxt = gsum_r + chunk;
    grp_end  = ctl2_r.valid && (ctl2_r.glast || ctl2_r.vlast);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
      ctl3_r <= '0;
      gsum_r <= '0;
    end else if (en) begin
      ctl2_r <= in_ctl;
      ctl3_r <= '{valid: grp_end, glast: ctl2_r.glast, vlast: ctl2_r.vlast,
                  scale: ctl2_r.scale};
      if (ctl2_r.valid) begin
        gsum_r <= grp_end ? '0 : gsum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && grp_end) begin
      gs_r <= gsum_nxt;
    end
  end

  assign out_ctl  = ctl3_r;
  assign gsum_out = gs_r;

endmodule

FILE: hw/rtl/ldq_accum.sv
`timescale 1ns / 1ps

module ldq_accum import ldq_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  stage_t                    in_ctl,
  input  logic signed [GSUM_W-1:0]  gs,
  input  logic                      out_ready,
  output logic                      en,
  output logic                      out_valid,
  output logic signed [TOTAL_W-1:0] dot_value
);

  stage_t                    ctl4_r;
  logic signed [SPROD_W-1:0] sprod_r;
  logic signed [TOTAL_W-1:0] total_r;
  logic signed [TOTAL_W-1:0] total_nxt;
  logic signed [TOTAL_W-1:0] dot_r;
  logic                      out_valid_r;
  logic                      emit;

  assign emit      = ctl4_r.valid && ctl4_r.vlast;
  assign en        = !(emit && out_valid_r && !out_ready);
  assign total_nxt = total_r + TOTAL_W'(sprod_r);

  always_ff @(posedge clk) begin
    if (en) begin
      sprod_r <= gs * in_ctl.scale;
    end
    if (en && emit) begin
      dot_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl4_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        ctl4_r <= in_ctl;
        if (ctl4_r.valid) begin
          total_r <= ctl4_r.vlast ? '0 : total_nxt;
        end
      end
      if (en && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign dot_value = dot_r;

endmodule

FILE: hw/rtl/lowbit_dequant_dot_product.sv
`timescale 1ns / 1ps

// channel   dir  modport  payload
// in_ch     in   sink     weight_bits, acts_lanes_*, valid_count, group_scale, group/vector_last
// out_ch    out  source   dot_value
// cfg_ch    in   sink     weight_format
//
// One chunk per cycle while not stalled; a vector's result is registered in the total stage.
// Five stages: lane multiply, 4-lane partial sums, group sum, scale multiply, total.
// All stages share one enable; it drops only while a finished result waits in the
// output register and another vector end sits in the last stage.
// rst_n is synchronous; format resets to int4, running group sum and total to zero. cfg_ch is always ready.

module lowbit_dequant_dot_product import ldq_pkg::*; #(
  parameter int LANES     = LANES_DEF,
  parameter int ACT_WIDTH = ACT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ldq_in_if.sink      in_ch,
  ldq_out_if.source   out_ch,
  ldq_cfg_if.sink     cfg_ch
);

  localparam int PW     = ACT_WIDTH + CODE_W;
  localparam int WPAD_W = (NIB_W * LANES > WBITS_W) ? NIB_W * LANES : WBITS_W;
  localparam int APAD_W = (LANES * ACT_WIDTH > ACT_BUS_W) ? LANES * ACT_WIDTH : ACT_BUS_W;

  logic [FMT_W-1:0]     fmt_r;
  logic                 en;
  logic [WPAD_W-1:0]    wpad;
  logic [APAD_W-1:0]    apad;
  logic [LANES-1:0]     lane_on;
  logic signed [PW-1:0] prods [LANES];
  stage_t               ctl1_r;
  stage_t               ctl3;
  logic signed [GSUM_W-1:0] gs;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_INT4;
    end else if (cfg_ch.valid) begin
      fmt_r <= cfg_ch.weight_format;
    end
  end

  assign wpad = WPAD_W'(in_ch.weight_bits);
  assign apad = APAD_W'({in_ch.acts_lanes_12_15, in_ch.acts_lanes_8_11,
                         in_ch.acts_lanes_4_7, in_ch.acts_lanes_0_3});

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    assign lane_on[i] = (in_ch.valid_count > COUNT_W'(i));

    ldq_lane #(.ACT_WIDTH(ACT_WIDTH)) u_lane (
      .clk     (clk),
      .en      (en),
      .fmt     (fmt_r),
      .lane_on (lane_on[i]),
      .nib     (wpad[NIB_W*i +: NIB_W]),
      .crumb   (wpad[CRUMB_W*i +: CRUMB_W]),
      .hib     (wpad[INT3_HI_BASE+i]),
      .act     (apad[ACT_WIDTH*i +: ACT_WIDTH]),
      .prod    (prods[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else if (en) begin
      ctl1_r.valid <= in_ch.valid;
      ctl1_r.glast <= in_ch.group_last;
      ctl1_r.vlast <= in_ch.vector_last;
      ctl1_r.scale <= in_ch.group_scale;
    end
  end

  ldq_merge #(.LANES(LANES), .ACT_WIDTH(ACT_WIDTH)) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_ctl   (ctl1_r),
    .prods    (prods),
    .out_ctl  (ctl3),
    .gsum_out (gs)
  );

  ldq_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctl    (ctl3),
    .gs        (gs),
    .out_ready (out_ch.ready),
    .en        (en),
    .out_valid (out_ch.valid),
    .dot_value (out_ch.dot_value)
  );

`ifndef NO_ASSERTIONS
  a_stall_behind_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid)
    else $error("input stalled with no result waiting");

  a_merge_only_group_ends: assert property (@(posedge clk) disable iff (!rst_n)
    ctl3.valid |-> (ctl3.glast || ctl3.vlast))
    else $error("merge stage passed a beat that ends no group");

  a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl1_r.valid && !en) |=> ctl1_r.valid)
    else $error("lane stage dropped a beat during stall");
`endif

endmodule

FILE: dv/lowbit_dequant_dot_product_tb.sv
`timescale 1ns / 1ps

module lowbit_dequant_dot_product_tb;
  import ldq_pkg::*;

  localparam int LANES        = LANES_DEF;
  localparam int ACT_W        = ACT_WIDTH_DEF;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 250;
  localparam int MAX_PRINTS   = 50;
  localparam logic [FMT_W-1:0] FMT_UNUSED = 2'd3;

  localparam logic [ACT_BUS_W-1:0] ACT_MIX = {
    64'h0F0F_F0F0_00FF_FF00, 64'hFEDC_BA98_7654_3210,
    64'h1234_5678_9ABC_DEF0, 64'h8000_7FFF_0001_FFFF
  };

  typedef struct {
    logic [WBITS_W-1:0]        wbits;
    logic [ACT_BUS_W-1:0]      acts;
    logic [COUNT_W-1:0]        count;
    logic signed [SCALE_W-1:0] scale;
    logic                      glast;
    logic                      vlast;
  } chunk_t;

  typedef struct {
    logic [FMT_W-1:0]          fmt;
    chunk_t                    item;
    bit                        typed;
    logic signed [TOTAL_W-1:0] dot;
  } row_t;

  row_t directed_rows [21] = '{
    '{FMT_INT4, '{64'h0, {16{16'h0100}}, 5'd16, 16'sh2000, 1'b0, 1'b1},
      1'b1, -64'sd268435456},
    '{FMT_INT4, '{64'hFFFF_FFFF_FFFF_FFFF, {16{16'h8000}}, 5'd16, 16'sh7FFF, 1'b0, 1'b1},
      1'b1, -64'sd120255414272},
    '{FMT_INT4, '{64'h0, {16{16'h8000}}, 5'd16, 16'sh8000, 1'b0, 1'b1},
      1'b1, -64'sd137438953472},
    '{FMT_INT4, '{64'h0123_4567_89AB_CDEF, {16{16'h7FFF}}, 5'd0, 16'sh7FFF, 1'b0, 1'b1},
      1'b1, 64'sd0},
    '{FMT_INT4, '{64'h8888_8888_8888_8888, {16{16'h7FFF}}, 5'd16, 16'sh1234, 1'b0, 1'b1},
      1'b1, 64'sd0},
    '{FMT_INT4, '{64'hDEAD_BEEF_CAFE_F00D, ACT_MIX, 5'd31, 16'sh3A5C, 1'b0, 1'b1},
      1'b0, 64'sd0},
    '{FMT_INT4, '{64'hFEDC_BA98_7654_3210, ACT_MIX, 5'd1, 16'sh2000, 1'b1, 1'b0},
      1'b0, 64'sd0},
    '{FMT_INT4, '{64'h0F1E_2D3C_4B5A_6978, ~ACT_MIX, 5'd7, 16'shC000, 1'b0, 1'b0},
      1'b0, 64'sd0},
    '{FMT_INT4, '{64'h7766_5544_3322_1100, ACT_MIX, 5'd16, 16'sh7FFF, 1'b1, 1'b1},
      1'b0, 64'sd0},
    '{FMT_INT4, '{64'h0011_2233_4455_6677, ~ACT_MIX, 5'd17, 16'sh0001, 1'b0, 1'b1},
      1'b0, 64'sd0},
    '{FMT_INT2, '{64'h0, {16{16'h0100}}, 5'd16, 16'sh2000, 1'b0, 1'b1},
      1'b1, -64'sd67108864},
    '{FMT_INT2, '{64'hFFFF_FFFF_FFFF_FFFF, {16{16'h8000}}, 5'd16, 16'sh8000, 1'b0, 1'b1},
      1'b1, 64'sd17179869184},
    '{FMT_INT2, '{64'hAAAA_5555_1B1B_E4E4, ACT_MIX, 5'd16, 16'sh5A5A, 1'b1, 1'b0},
      1'b0, 64'sd0},
    '{FMT_INT2, '{64'h5555_AAAA_E4E4_1B1B, ~ACT_MIX, 5'd9, 16'shA5A5, 1'b0, 1'b1},
      1'b0, 64'sd0},
    '{FMT_INT3, '{64'h0, {16{16'h0100}}, 5'd16, 16'sh2000, 1'b0, 1'b1},
      1'b1, -64'sd134217728},
    '{FMT_INT3, '{64'h0000_FFFF_FFFF_FFFF, {16{16'h8000}}, 5'd16, 16'sh8000, 1'b0, 1'b1},
      1'b1, 64'sd51539607552},
    '{FMT_INT3, '{64'hFFFF_0000_FFFF_FFFF, {16{16'h8000}}, 5'd16, 16'sh8000, 1'b0, 1'b1},
      1'b1, -64'sd17179869184},
    '{FMT_INT3, '{64'h0000_A5A5_3C3C_C3C3, ACT_MIX, 5'd12, 16'sh1357, 1'b1, 1'b0},
      1'b0, 64'sd0},
    '{FMT_INT3, '{64'hC0DE_5A3C_9E71_04B8, ~ACT_MIX, 5'd16, 16'shECA8, 1'b0, 1'b1},
      1'b0, 64'sd0},
    '{FMT_UNUSED, '{64'h0, {16{16'h0100}}, 5'd16, 16'sh2000, 1'b0, 1'b1},
      1'b1, -64'sd268435456},
    '{FMT_UNUSED, '{64'hFFFF_FFFF_FFFF_FFFF, {16{16'h0100}}, 5'd16, 16'sh2000, 1'b0, 1'b1},
      1'b1, 64'sd234881024}
  };

  logic clk;
  logic rst_n;

  ldq_in_if  in_ch ();
  ldq_out_if out_ch ();
  ldq_cfg_if cfg_ch ();

  lowbit_dequant_dot_product uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  logic [FMT_W-1:0]          model_fmt;
  logic [GSUM_W-1:0]         model_gsum;
  logic [TOTAL_W-1:0]        model_total;
  logic signed [TOTAL_W-1:0] pending_dots [$];

  int n_items;
  int n_dots;
  int n_errors;
  bit src_idle_en;
  bit sink_idle_en;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("timeout: %0d dot products still outstanding", pending_dots.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("MISMATCH t=%0t %s: got %0d want %0d", $time, what,
               $signed(got), $signed(want));
  endtask

  function automatic int weight_code(input logic [WBITS_W-1:0] w, input int lane,
                                     input logic [FMT_W-1:0] fmt);
    case (fmt)
      FMT_INT2: return int'(w[2*lane +: 2]) - INT2_BIAS;
      FMT_INT3: return int'({w[INT3_HI_BASE+lane], w[2*lane +: 2]}) - INT3_BIAS;
      default:  return int'(w[4*lane +: 4]) - INT4_BIAS;
    endcase
  endfunction

  // Advances the dot product state by one chunk.
  task automatic accumulate_chunk(input chunk_t c, output bit done,
                                  output logic signed [TOTAL_W-1:0] dot);
    int n;
    longint chunk_sum;
    logic signed [ACT_W-1:0] a;
    n = (c.count > LANES) ? LANES : int'(c.count);
    chunk_sum = 0;
    for (int i = 0; i < n; i++) begin
      a = c.acts[ACT_W*i +: ACT_W];
      chunk_sum += longint'(a) * longint'(weight_code(c.wbits, i, model_fmt));
    end
    model_gsum = model_gsum + chunk_sum[31:0];
    if (c.glast || c.vlast) begin
      model_total = model_total + longint'($signed(model_gsum)) * longint'(c.scale);
      model_gsum = '0;
    end
    done = c.vlast;
    dot = model_total;
    if (c.vlast) model_total = '0;
  endtask

  function automatic chunk_t rand_chunk(input bit gl, input bit vl);
    chunk_t c;
    c.wbits = {$urandom, $urandom};
    for (int i = 0; i < LANES; i++) begin
      case ($urandom_range(0, 7))
        0:       c.acts[ACT_W*i +: ACT_W] = 16'h8000;
        1:       c.acts[ACT_W*i +: ACT_W] = 16'h7FFF;
        default: c.acts[ACT_W*i +: ACT_W] = 16'($urandom);
      endcase
    end
    c.count = ($urandom_range(0, 9) < 7) ? 5'd16 : 5'($urandom_range(0, 31));
    case ($urandom_range(0, 9))
      0:       c.scale = 16'sh8000;
      1:       c.scale = 16'sh7FFF;
      default: c.scale = 16'($urandom);
    endcase
    c.glast = gl;
    c.vlast = vl;
    return c;
  endfunction

  task automatic send_chunk(input chunk_t c, input bit typed,
                            input logic signed [TOTAL_W-1:0] typed_dot);
    bit done;
    logic signed [TOTAL_W-1:0] dot;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.weight_bits      <= c.wbits;
    in_ch.acts_lanes_0_3   <= c.acts[63:0];
    in_ch.acts_lanes_4_7   <= c.acts[127:64];
    in_ch.acts_lanes_8_11  <= c.acts[191:128];
    in_ch.acts_lanes_12_15 <= c.acts[255:192];
    in_ch.valid_count      <= c.count;
    in_ch.group_scale      <= c.scale;
    in_ch.group_last       <= c.glast;
    in_ch.vector_last      <= c.vlast;
    do @(posedge clk); while (!in_ch.ready);
    n_items++;
    accumulate_chunk(c, done, dot);
    if (done) pending_dots.push_back(typed ? typed_dot : dot);
  endtask

  task automatic send_vector();
    int groups;
    int chunks;
    groups = $urandom_range(1, 4);
    for (int g = 0; g < groups; g++) begin
      chunks = $urandom_range(1, 4);
      for (int k = 0; k < chunks; k++)
        send_chunk(rand_chunk(k == chunks - 1, g == groups - 1 && k == chunks - 1),
                   1'b0, '0);
    end
  endtask

  // Trailing chunks without vector end may still be in the pipe after the last result.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_dots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_format(input logic [FMT_W-1:0] f);
    wait_idle();
    cfg_ch.valid         <= 1'b1;
    cfg_ch.weight_format <= f;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    model_fmt = f;
  endtask

  // Result receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        for (int h = 0; h < HOLD_CYCLES; h++) @(posedge clk);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic signed [TOTAL_W-1:0] want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        n_dots++;
        if (pending_dots.size() == 0) begin
          report_mismatch("unexpected dot_value", out_ch.dot_value, '0);
        end else begin
          want = pending_dots.pop_front();
          if (out_ch.dot_value !== want)
            report_mismatch("dot_value", out_ch.dot_value, want);
        end
      end
    end
  end

  initial begin
    logic [FMT_W-1:0] phase_fmts [4];
    logic [FMT_W-1:0] f;
    int n0;
    int guard;
    phase_fmts = '{FMT_INT2, FMT_INT3, FMT_UNUSED, FMT_INT4};
    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.weight_bits      = '0;
    in_ch.acts_lanes_0_3   = '0;
    in_ch.acts_lanes_4_7   = '0;
    in_ch.acts_lanes_8_11  = '0;
    in_ch.acts_lanes_12_15 = '0;
    in_ch.valid_count      = '0;
    in_ch.group_scale      = '0;
    in_ch.group_last       = 1'b0;
    in_ch.vector_last      = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.weight_format   = FMT_INT4;
    model_fmt              = FMT_INT4;
    model_gsum             = '0;
    model_total            = '0;
    n_items                = 0;
    n_dots                 = 0;
    n_errors               = 0;
    hold_req               = 1'b0;
    src_idle_en            = 1'b1;
    sink_idle_en           = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].fmt != model_fmt) set_format(directed_rows[r].fmt);
      send_chunk(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].dot);
    end

    for (int p = 0; p < 8; p++) begin
      f = (p < 4) ? phase_fmts[p] : FMT_W'($urandom_range(0, 3));
      set_format(f);
      src_idle_en  = (p != 7) && (p % 3 != 1);
      sink_idle_en = (p != 7) && (p % 3 != 2);
      if (p == 2) begin
        // receiver holds off while every beat ends a vector, so the pipe backs up
        src_idle_en = 1'b0;
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++) send_chunk(rand_chunk(1'b1, 1'b1), 1'b0, '0);
        src_idle_en = 1'b1;
      end
      n0 = n_items;
      while (n_items - n0 < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0)
          send_chunk(rand_chunk($urandom_range(0, 1) == 1, $urandom_range(0, 3) == 0),
                     1'b0, '0);
        else
          send_vector();
      end
    end
    in_ch.valid <= 1'b0;

    guard = 0;
    while (pending_dots.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_dots.size() != 0) begin
      report_mismatch("dot products never produced", pending_dots.size(), 0);
    end

    $display("run: %0d chunks in, %0d dot products out, int4/int2/int3/unused formats,",
             n_items, n_dots);
    $display("     counts 0..31, group/vector ends, %0d-cycle output hold; %0d mismatches",
             HOLD_CYCLES, n_errors);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
